>>> rtl/http_request_tokenizer_unit_macros.svh
// Assertion macros used by the checker file.
// The including module must provide i_clk and i_rst_n.
`ifndef HTTP_REQUEST_TOKENIZER_UNIT_MACROS_SVH
`define HTTP_REQUEST_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hrt_pkg.sv
package hrt_pkg;

    // Default widths
    localparam int OFFSET_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;

    // Token type codes
    localparam logic [2:0] TT_METHOD = 3'd0;
    localparam logic [2:0] TT_PATH   = 3'd1;
    localparam logic [2:0] TT_PROTO  = 3'd2;
    localparam logic [2:0] TT_KEY    = 3'd3;
    localparam logic [2:0] TT_VALUE  = 3'd4;
    localparam logic [2:0] TT_BODY   = 3'd5;

    // Register reset value
    localparam logic [7:0] CAPACITY_RST = 8'd255;

    // Input item held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       is_last;
    } t_item;

    // One result
    typedef struct packed {
        logic        token_valid;
        logic [2:0]  token_type;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic [7:0]  slot_index;
        logic        request_done;
        logic        malformed;
        logic [7:0]  total_tokens;
    } t_rsp;

endpackage

>>> rtl/hrt_cfg_if.sv
interface hrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hrt_req_if.sv
interface hrt_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

>>> rtl/hrt_rsp_if.sv
interface hrt_rsp_if;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic [2:0]  token_type;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [7:0]  slot_index;
    logic        request_done;
    logic        malformed;
    logic [7:0]  total_tokens;

    modport source (
        output valid, output token_valid, output token_type, output span_start,
        output span_end, output slot_index, output request_done, output malformed,
        output total_tokens, input ready
    );
    modport sink (
        input valid, input token_valid, input token_type, input span_start,
        input span_end, input slot_index, input request_done, input malformed,
        input total_tokens, output ready
    );
endinterface

>>> rtl/hrt_in_stage.sv
module hrt_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hrt_req_if.sink        i_req,
    input  logic           i_take,
    output hrt_pkg::t_item o_item
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_is_last;
    logic       w_load;

    // Register is free when empty or being drained this cycle
    assign w_load      = !r_valid || i_take;
    assign i_req.ready = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_req.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_load && i_req.valid) begin
            r_data_byte <= i_req.data_byte;
            r_is_last   <= i_req.is_last;
        end
    end

    assign o_item.valid     = r_valid;
    assign o_item.data_byte = r_data_byte;
    assign o_item.is_last   = r_is_last;

endmodule

>>> rtl/hrt_core.sv
module hrt_core #(
    parameter int OFFSET_BITS = hrt_pkg::OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = hrt_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hrt_cfg_if.sink        i_cfg,
    input  hrt_pkg::t_item i_item,
    input  logic           i_out_can_load,
    output logic           o_take,
    output logic           o_push,
    output hrt_pkg::t_rsp  o_rsp
);

    // Parse phases
    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_PATH   = 3'd1;
    localparam logic [2:0] PH_PROTO  = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;
    localparam logic [2:0] PH_BAD    = 3'd6;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int SLOT_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [OFFSET_BITS:0]   OFF_MAX = {1'b0, {OFFSET_BITS{1'b1}}};
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]             r_phase, n_phase;
    logic                   r_cr, n_cr;
    logic                   r_colon, n_colon;
    logic [OFFSET_BITS-1:0] r_field_begin, n_field_begin;
    logic [OFFSET_BITS:0]   r_pos, n_pos;
    logic [COUNT_BITS-1:0]  r_tokens, n_tokens;
    logic                   r_error, n_error;
    logic [7:0]             r_capacity;

    logic                   w_is_sp, w_is_lf, w_crlf;
    logic                   w_overlong;
    logic [OFFSET_BITS-1:0] w_pos_lo, w_pos_inc, w_pos_dec;
    logic                   w_take;
    logic [2:0]             w_type;
    logic [OFFSET_BITS-1:0] w_start, w_end;
    logic                   w_emit;
    logic                   w_last;
    logic                   w_has_result;
    logic                   w_fire;

    // Configuration register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= hrt_pkg::CAPACITY_RST;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    // Byte classification
    assign w_last    = i_item.is_last;
    assign w_is_sp   = (i_item.data_byte == CH_SP);
    assign w_is_lf   = (i_item.data_byte == CH_LF);
    assign w_crlf    = w_is_lf && r_cr;
    assign w_pos_lo  = r_pos[OFFSET_BITS-1:0];
    assign w_pos_inc = w_pos_lo + 1'b1;
    assign w_pos_dec = w_pos_lo - 1'b1;
    assign w_overlong = (r_phase != PH_BAD) && (r_pos >= OFF_MAX);

    // Phase step: at most one token per byte
    always_comb begin
        n_phase       = r_phase;
        n_field_begin = r_field_begin;
        n_error       = r_error;
        n_cr          = (i_item.data_byte == CH_CR);
        n_colon       = (i_item.data_byte == CH_COLON);
        w_take        = 1'b0;
        w_type        = hrt_pkg::TT_METHOD;
        w_start       = r_field_begin;
        w_end         = w_pos_lo;

        if (w_overlong) begin
            n_error = 1'b1;
            n_phase = PH_BAD;
        end else begin
            unique case (r_phase)
                PH_METHOD, PH_PATH: begin
                    if (w_is_sp) begin
                        w_take        = 1'b1;
                        w_type        = (r_phase == PH_METHOD) ? hrt_pkg::TT_METHOD
                                                               : hrt_pkg::TT_PATH;
                        n_field_begin = w_pos_inc;
                        n_phase       = r_phase + 3'd1;
                    end
                end
                PH_PROTO: begin
                    if (w_crlf) begin
                        w_take        = 1'b1;
                        w_type        = hrt_pkg::TT_PROTO;
                        w_end         = w_pos_dec;
                        n_field_begin = w_pos_inc;
                        n_phase       = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (w_crlf) begin
                        // Empty line ends the headers; CRLF inside a key is an error
                        if (({1'b0, r_field_begin} + 1'b1) == r_pos) begin
                            n_field_begin = w_pos_inc;
                            n_phase       = PH_BODY;
                        end else begin
                            n_error = 1'b1;
                            n_phase = PH_BAD;
                        end
                    end else if (w_is_sp && r_colon) begin
                        w_take        = 1'b1;
                        w_type        = hrt_pkg::TT_KEY;
                        w_end         = w_pos_dec;
                        n_field_begin = w_pos_inc;
                        n_phase       = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (w_crlf) begin
                        w_take        = 1'b1;
                        w_type        = hrt_pkg::TT_VALUE;
                        w_end         = w_pos_dec;
                        n_field_begin = w_pos_inc;
                        n_phase       = PH_KEY;
                    end
                end
                default: begin
                end
            endcase
        end

        // Body token on the last byte when non-empty
        if (w_last && (n_phase == PH_BODY) && ({1'b0, n_field_begin} <= r_pos)) begin
            w_take  = 1'b1;
            w_type  = hrt_pkg::TT_BODY;
            w_start = n_field_begin;
            w_end   = w_pos_inc;
        end
    end

    // Position and token count, both saturating
    assign n_pos    = (r_pos <= OFF_MAX) ? r_pos + 1'b1 : r_pos;
    assign n_tokens = (w_take && (r_tokens < CNT_MAX)) ? r_tokens + 1'b1 : r_tokens;
    assign w_emit   = w_take && (SLOT_W'(r_tokens) < SLOT_W'(r_capacity));

    // Result fields
    always_comb begin
        o_rsp              = '0;
        o_rsp.token_valid  = w_emit;
        o_rsp.request_done = w_last;
        if (w_emit) begin
            o_rsp.token_type = w_type;
            o_rsp.span_start = 16'(w_start);
            o_rsp.span_end   = 16'(w_end);
            o_rsp.slot_index = 8'(r_tokens);
        end
        if (w_last) begin
            o_rsp.malformed    = n_error || (n_phase != PH_BODY);
            o_rsp.total_tokens = 8'(n_tokens);
        end
    end

    // Item leaves the input register when it has no result or its result has room
    assign w_has_result = w_emit || w_last;
    assign w_fire       = i_item.valid && (!w_has_result || i_out_can_load);
    assign o_take       = w_fire;
    assign o_push       = w_fire && w_has_result;

    // State update; the last byte returns everything to the idle request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD;
            r_cr          <= 1'b0;
            r_colon       <= 1'b0;
            r_field_begin <= '0;
            r_pos         <= '0;
            r_tokens      <= '0;
            r_error       <= 1'b0;
        end else if (w_fire) begin
            if (w_last) begin
                r_phase       <= PH_METHOD;
                r_cr          <= 1'b0;
                r_colon       <= 1'b0;
                r_field_begin <= '0;
                r_pos         <= '0;
                r_tokens      <= '0;
                r_error       <= 1'b0;
            end else begin
                r_phase       <= n_phase;
                r_cr          <= n_cr;
                r_colon       <= n_colon;
                r_field_begin <= n_field_begin;
                r_pos         <= n_pos;
                r_tokens      <= n_tokens;
                r_error       <= n_error;
            end
        end
    end

endmodule

>>> rtl/hrt_out_stage.sv
module hrt_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrt_pkg::t_rsp i_rsp,
    output logic          o_can_load,
    hrt_rsp_if.source     o_rsp
);

    logic          r_valid;
    hrt_pkg::t_rsp r_rsp;

    // Free when empty or the current request is being taken
    assign o_can_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.token_valid  = r_rsp.token_valid;
    assign o_rsp.token_type   = r_rsp.token_type;
    assign o_rsp.span_start   = r_rsp.span_start;
    assign o_rsp.span_end     = r_rsp.span_end;
    assign o_rsp.slot_index   = r_rsp.slot_index;
    assign o_rsp.request_done = r_rsp.request_done;
    assign o_rsp.malformed    = r_rsp.malformed;
    assign o_rsp.total_tokens = r_rsp.total_tokens;

endmodule

>>> rtl/http_request_tokenizer_unit.sv
// A byte accepted into the input register passes through the step logic into the result register on o_rsp.
// Throughput: one byte per cycle; stalls only when a result waits on a full output register.
// The per-byte state update (phase, offsets, count) sits between input and output registers.
// Reset: synchronous, active low; clears parse state, empties both registers,
// and sets token_capacity to 255.
module http_request_tokenizer_unit #(
    parameter int OFFSET_BITS = hrt_pkg::OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = hrt_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrt_cfg_if.sink   i_cfg,
    hrt_req_if.sink   i_req,
    hrt_rsp_if.source o_rsp
);

    hrt_pkg::t_item w_item;
    hrt_pkg::t_rsp  w_rsp;
    logic           w_take;
    logic           w_push;
    logic           w_can_load;

    // Input register
    hrt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // Tokenizer state and step logic
    hrt_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (i_cfg),
        .i_item         (w_item),
        .i_out_can_load (w_can_load),
        .o_take         (w_take),
        .o_push         (w_push),
        .o_rsp          (w_rsp)
    );

    // Result register
    hrt_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_rsp      (w_rsp),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

endmodule

>>> rtl/hrt_checker.sv
`include "http_request_tokenizer_unit_macros.svh"

module hrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_token_valid,
    input logic [2:0]  i_token_type,
    input logic [15:0] i_span_start,
    input logic [15:0] i_span_end,
    input logic [7:0]  i_slot_index,
    input logic        i_request_done,
    input logic        i_malformed,
    input logic [7:0]  i_total_tokens
);

    logic [53:0] w_payload;
    logic        w_stall;
    logic        w_body;

    assign w_payload = {i_token_valid, i_token_type, i_span_start, i_span_end,
                        i_slot_index, i_request_done, i_malformed, i_total_tokens};
    assign w_stall   = i_rsp_valid && !i_rsp_ready;
    assign w_body    = i_rsp_valid && i_token_valid && (i_token_type == hrt_pkg::TT_BODY);

    // A stalled request keeps its contents
    `HRT_ASSERT_NEXT(a_rsp_hold, w_stall, i_rsp_valid && $stable(w_payload), "rsp changed under stall")
    // Nothing is offered right after reset
    `HRT_ASSERT_NOW(a_reset_idle, $past(!i_rst_n), !i_rsp_valid, "rsp valid right after reset")
    // Every result carries a token or ends a request
    `HRT_ASSERT_NOW(a_no_empty, i_rsp_valid, i_token_valid || i_request_done, "empty result")
    // A body token only comes with the end of the request
    `HRT_ASSERT_NOW(a_body_at_end, w_body, i_request_done, "body token before last byte")

endmodule

bind http_request_tokenizer_unit hrt_checker u_hrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_token_valid  (o_rsp.token_valid),
    .i_token_type   (o_rsp.token_type),
    .i_span_start   (o_rsp.span_start),
    .i_span_end     (o_rsp.span_end),
    .i_slot_index   (o_rsp.slot_index),
    .i_request_done (o_rsp.request_done),
    .i_malformed    (o_rsp.malformed),
    .i_total_tokens (o_rsp.total_tokens)
);

>>> verif/http_request_tokenizer_unit_test.sv
module http_request_tokenizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_BYTES = 300;
    localparam int          SETTLE_EDGES = 4;

    localparam logic [16:0] OFFSET_CEIL = 17'd65535;
    localparam logic [7:0]  COUNT_CEIL  = 8'd255;

    // Bytes the parser reacts to
    localparam logic [7:0] SP     = 8'h20;
    localparam logic [7:0] CR     = 8'h0D;
    localparam logic [7:0] LF     = 8'h0A;
    localparam logic [7:0] COLON  = 8'h3A;
    localparam logic [7:0] FILLER = 8'h5F;

    typedef enum logic [2:0] {
        IN_METHOD, IN_PATH, IN_PROTO, IN_KEY, IN_VALUE, IN_BODY, IN_BAD
    } parse_phase_e;

    // What a generated field must not contain
    typedef enum {FK_WORD, FK_LINE, FK_KEY} field_kind_e;

    // Tracks parse state per accepted byte and holds the token spans still due
    class token_scoreboard;
        hrt_pkg::t_rsp expected_spans[$];
        int            errors;
        int            checked;
        logic [7:0]    capacity;
        parse_phase_e  phase;
        bit            cr_prev;
        bit            colon_prev;
        logic [16:0]   field_begin;
        logic [16:0]   byte_pos;
        logic [7:0]    tokens_seen;
        bit            error_seen;

        function new();
            errors   = 0;
            checked  = 0;
            capacity = hrt_pkg::CAPACITY_RST;
            clear_request();
        endfunction

        function void clear_request();
            phase       = IN_METHOD;
            cr_prev     = 1'b0;
            colon_prev  = 1'b0;
            field_begin = '0;
            byte_pos    = '0;
            tokens_seen = '0;
            error_seen  = 1'b0;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        // Every token takes the next slot; only slots below capacity are reported
        function void claim_slot(inout hrt_pkg::t_rsp r, input logic [2:0] kind,
                                 input logic [16:0] first, input logic [16:0] past);
            logic [7:0] slot;
            slot = tokens_seen;
            if (tokens_seen != COUNT_CEIL) tokens_seen++;
            if (slot < capacity) begin
                r.token_valid = 1'b1;
                r.token_type  = kind;
                r.span_start  = first[15:0];
                r.span_end    = past[15:0];
                r.slot_index  = slot;
            end
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            hrt_pkg::t_rsp r;
            logic [16:0]   pos;
            bit            cr;
            bit            colon;
            r          = '0;
            pos        = byte_pos;
            cr         = cr_prev;
            colon      = colon_prev;
            cr_prev    = (b == CR);
            colon_prev = (b == COLON);

            // offset overflow poisons the rest of the request
            if (phase != IN_BAD && pos >= OFFSET_CEIL) begin
                error_seen = 1'b1;
                phase      = IN_BAD;
            end else begin
                case (phase)
                    IN_METHOD: begin
                        if (b == SP) begin
                            claim_slot(r, hrt_pkg::TT_METHOD, field_begin, pos);
                            field_begin = pos + 17'd1;
                            phase       = IN_PATH;
                        end
                    end
                    IN_PATH: begin
                        if (b == SP) begin
                            claim_slot(r, hrt_pkg::TT_PATH, field_begin, pos);
                            field_begin = pos + 17'd1;
                            phase       = IN_PROTO;
                        end
                    end
                    IN_PROTO: begin
                        if (b == LF && cr) begin
                            claim_slot(r, hrt_pkg::TT_PROTO, field_begin, pos - 17'd1);
                            field_begin = pos + 17'd1;
                            phase       = IN_KEY;
                        end
                    end
                    IN_KEY: begin
                        if (b == LF && cr) begin
                            // bare CRLF ends headers; CRLF after key text is an error
                            if (pos == field_begin + 17'd1) begin
                                field_begin = pos + 17'd1;
                                phase       = IN_BODY;
                            end else begin
                                error_seen = 1'b1;
                                phase      = IN_BAD;
                            end
                        end else if (b == SP && colon) begin
                            claim_slot(r, hrt_pkg::TT_KEY, field_begin, pos - 17'd1);
                            field_begin = pos + 17'd1;
                            phase       = IN_VALUE;
                        end
                    end
                    IN_VALUE: begin
                        if (b == LF && cr) begin
                            claim_slot(r, hrt_pkg::TT_VALUE, field_begin, pos - 17'd1);
                            field_begin = pos + 17'd1;
                            phase       = IN_KEY;
                        end
                    end
                    default: ;
                endcase
            end

            if (pos <= OFFSET_CEIL) byte_pos = pos + 17'd1;

            if (last && phase == IN_BODY && field_begin < pos + 17'd1)
                claim_slot(r, hrt_pkg::TT_BODY, field_begin, pos + 17'd1);

            if (last || r.token_valid) begin
                r.request_done = last;
                r.malformed    = last && (error_seen || phase != IN_BODY);
                r.total_tokens = last ? tokens_seen : 8'd0;
                expected_spans.push_back(r);
            end

            if (last) clear_request();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(hrt_pkg::t_rsp got);
            hrt_pkg::t_rsp want;
            if (expected_spans.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = expected_spans.pop_front();
            checked++;
            compare_field("token_valid", 16'(want.token_valid), 16'(got.token_valid));
            compare_field("token_type", 16'(want.token_type), 16'(got.token_type));
            compare_field("span_start", want.span_start, got.span_start);
            compare_field("span_end", want.span_end, got.span_end);
            compare_field("slot_index", 16'(want.slot_index), 16'(got.slot_index));
            compare_field("request_done", 16'(want.request_done), 16'(got.request_done));
            compare_field("malformed", 16'(want.malformed), 16'(got.malformed));
            compare_field("total_tokens", 16'(want.total_tokens), 16'(got.total_tokens));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrt_cfg_if cfg_bus();
    hrt_req_if req_bus();
    hrt_rsp_if rsp_bus();

    http_request_tokenizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    token_scoreboard sb = new();

    logic [7:0]  req_text[$];
    int          bytes_sent    = 0;
    int          requests_sent = 0;
    int          cap_writes    = 0;
    int          holds         = 0;
    int unsigned cycle_count   = 0;
    bit          sender_idle   = 1'b1;
    bit          receiver_idle = 1'b1;
    bit          hold_output   = 1'b0;

    always #6ns i_clk = ~i_clk;

    // Request text builders
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) req_text.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        req_text.push_back(CR);
        req_text.push_back(LF);
    endfunction

    // Field content: mostly letters, with lone CR and ':' and arbitrary bytes
    function automatic void add_field(field_kind_e kind, int unsigned len);
        logic [7:0] c;
        int         roll;
        repeat (len) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) c = 8'h61 + 8'($urandom_range(0, 25));
            else if (roll == 6) c = COLON;
            else if (roll == 7) c = CR;
            else c = 8'($urandom_range(0, 255));
            case (kind)
                FK_WORD: if (c == SP) c = FILLER;
                FK_LINE: if (c == LF) c = FILLER;
                default: if (c == SP || c == LF) c = FILLER;
            endcase
            req_text.push_back(c);
        end
    endfunction

    function automatic void add_noise(int unsigned len);
        repeat (len) begin
            case ($urandom_range(0, 9))
                0: req_text.push_back(SP);
                1: req_text.push_back(CR);
                2: req_text.push_back(LF);
                3: req_text.push_back(COLON);
                default: req_text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void add_request_line();
        add_field(FK_WORD, $urandom_range(0, 6));
        req_text.push_back(SP);
        add_field(FK_WORD, $urandom_range(0, 8));
        req_text.push_back(SP);
        add_field(FK_LINE, $urandom_range(0, 8));
        put_crlf();
    endfunction

    function automatic void add_header();
        add_field(FK_KEY, $urandom_range(0, 6));
        req_text.push_back(COLON);
        req_text.push_back(SP);
        add_field(FK_LINE, $urandom_range(0, 8));
        put_crlf();
    endfunction

    function automatic void add_wellformed(int unsigned n_hdr, int unsigned body_len);
        add_request_line();
        repeat (n_hdr) add_header();
        put_crlf();
        repeat (body_len) req_text.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One byte request on the input channel, after a random gap
    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.data_byte <= b;
        req_bus.is_last   <= last;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_request();
        foreach (req_text[i]) send_byte(req_text[i], i == req_text.size() - 1);
        req_text.delete();
        requests_sent++;
    endtask

    // Capacity changes only once the block has drained
    task automatic write_capacity(logic [7:0] value);
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_EDGES) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.capacity = value;
        cap_writes++;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_output) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
                holds++;
            end
            stall = receiver_idle ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_result(hrt_pkg::t_rsp'{rsp_bus.token_valid, rsp_bus.token_type,
                                            rsp_bus.span_start, rsp_bus.span_end,
                                            rsp_bus.slot_index, rsp_bus.request_done,
                                            rsp_bus.malformed, rsp_bus.total_tokens});
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int         random_start;
        int         cut;
        logic [7:0] cap_pick;
        logic [7:0] cap_list[3];

        i_rst_n           <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.data      <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.data_byte <= '0;
        req_bus.is_last   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every token type, empty body, lone CR and ':'
        write_capacity(8'd255);
        put_text("G P H"); put_crlf(); put_text("K: V"); put_crlf(); put_crlf();
        put_text("B");
        send_request();
        put_text("M P H"); put_crlf(); put_crlf();
        send_request();
        put_text("M"); req_text.push_back(CR); put_text(" P:x H"); req_text.push_back(CR);
        put_crlf(); put_text("k:"); req_text.push_back(CR); put_text(": v:");
        req_text.push_back(CR); put_crlf(); put_crlf();
        send_request();

        // CRLF in a header key, then trailing bytes that are ignored
        put_text("M P H"); put_crlf(); put_text("key"); put_crlf(); put_text("zz");
        send_request();

        // Incomplete: the last byte still closes the path
        put_text("M P ");
        send_request();

        // Single byte requests
        req_text.push_back(8'hFF); send_request();
        req_text.push_back(8'h00); send_request();
        req_text.push_back(SP);    send_request();

        // Tokens past capacity are counted, not emitted
        cap_list = '{8'd0, 8'd1, 8'd5};
        foreach (cap_list[k]) begin
            write_capacity(cap_list[k]);
            put_text("G P H"); put_crlf(); put_text("K: V"); put_crlf(); put_crlf();
            put_text("B");
            send_request();
        end

        // Random requests, mostly well formed
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 9))
                    0:          cap_pick = 8'd0;
                    1, 2:       cap_pick = 8'd255;
                    3, 4, 5, 6: cap_pick = 8'($urandom_range(1, 8));
                    default:    cap_pick = 8'($urandom_range(0, 255));
                endcase
                write_capacity(cap_pick);
            end
            sender_idle   = $urandom_range(0, 4) != 0;
            receiver_idle = $urandom_range(0, 4) != 0;
            case ($urandom_range(0, 99)) inside
                [0:69]: add_wellformed($urandom_range(0, 5), $urandom_range(0, 12));
                [70:84]: begin
                    add_wellformed($urandom_range(0, 4), $urandom_range(0, 6));
                    cut = $urandom_range(1, req_text.size());
                    while (req_text.size() > cut) void'(req_text.pop_back());
                end
                [85:92]: begin
                    add_request_line();
                    repeat ($urandom_range(0, 2)) add_header();
                    req_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
                    add_field(FK_KEY, $urandom_range(0, 4));
                    put_crlf();
                    add_noise($urandom_range(0, 8));
                end
                default: add_noise($urandom_range(1, 30));
            endcase
            send_request();
        end

        // Count saturation while the output side holds off; short empty headers
        write_capacity(8'd255);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        add_request_line();
        repeat (128) begin
            put_text(": ");
            put_crlf();
        end
        put_crlf();
        put_text("z");
        hold_output = 1'b1;
        send_request();

        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests, %0d bytes, %0d capacity writes, %0d long hold-offs",
                 requests_sent, bytes_sent, cap_writes, holds);
        $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
